// ----- hdl/fsf_pkg.sv -----
// ----------------------------------------------------------------------------
// Fire risk score fusion package
// Shared constants, widths, sample and divider structs, and sequencer states.
// ----------------------------------------------------------------------------
package fsf_pkg;

	localparam int RING_DEPTH  = 16;
	localparam int MIN_SAMPLES = 5;

	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int KW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int TS_W  = 12 + CNT_W;
	localparam int TN_W  = TS_W + 11;
	localparam int TD_W  = $clog2(720 * RING_DEPTH + 1);
	localparam int LS_W  = 16 + CNT_W;

	localparam int TPROD_W = $clog2(4000 * 720 * RING_DEPTH);
	localparam int NUM_W   = (TPROD_W > 29) ? TPROD_W : 29;
	localparam int DEN_W   = 32;
	localparam int Q_W     = 13;
	localparam int SH_W    = DEN_W + Q_W - 1;
	localparam int QC_W    = $clog2(Q_W + 1);

	localparam int INTERVAL_RST = 1000;
	localparam int SCORE_MAX    = 10000;
	localparam int FIRE_TH      = 7000;
	localparam int RISE_K       = 93750;
	localparam int RISE_MAX     = 3000;
	localparam int TEMP_OFS     = 560;
	localparam int TEMP_SPAN    = 720;
	localparam int TEMP_MAX     = 4000;
	localparam int AIR_SAT      = 500;
	localparam int AIR_MAX      = 2000;
	localparam int LUX_DARK     = 20;
	localparam int LUX_K        = 50;
	localparam int DECAY_NEW_TH = 2000;
	localparam int DECAY_S_TH   = 3000;
	localparam int DECAY_STEP   = 500;

	typedef struct packed {
		logic [31:0] ts;
		logic [11:0] temp;
		logic [15:0] air;
		logic [15:0] lux;
	} sample_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic           busy;
		logic           done;
		logic [Q_W-1:0] q;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_RWAIT,
		ST_TPRE,
		ST_TCHK,
		ST_TWAIT,
		ST_LCHK,
		ST_LWAIT,
		ST_UPD,
		ST_FIN
	} fsf_state_t;

endpackage

// ----- hdl/fsf_cell.sv -----
// ----------------------------------------------------------------------------
// Fire risk score fusion history cell
// One stored sample of the history chain, loaded from its neighbor on shift.
// ----------------------------------------------------------------------------
module fsf_cell (
	input  logic             clk,
	input  logic             shift_en,
	input  fsf_pkg::sample_t d,
	output fsf_pkg::sample_t q
);
	import fsf_pkg::*;

	sample_t smp_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			smp_q <= d;
		end
	end

	assign q = smp_q;

endmodule

// ----- hdl/fsf_div.sv -----
// ----------------------------------------------------------------------------
// Fire risk score fusion divider
// Restoring divider, one quotient bit per cycle; the top bit flags overflow.
// ----------------------------------------------------------------------------
module fsf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fsf_pkg::div_req_t req,
	output fsf_pkg::div_rsp_t rsp
);
	import fsf_pkg::*;

	logic [NUM_W-1:0] rem_q;
	logic [SH_W-1:0]  dsh_q;
	logic [Q_W-1:0]   quo_q;
	logic [QC_W-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             fit;

	assign fit = SH_W'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= QC_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= {req.den, {(Q_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (fit) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[Q_W-2:0], fit};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.q    = quo_q;

endmodule

// ----- hdl/fire_risk_score_fusion_top.sv -----
// ----------------------------------------------------------------------------
// Fire risk score fusion top level
// Interval gate, chain of history cells walked oldest to newest, and scoring.
// ----------------------------------------------------------------------------
// Flow: a rejected sample, or one leaving fewer than the minimum stored, goes from the
// input transfer straight to the result register; otherwise the chain is walked, with
// a division for each temperature rise and up to two more for the mean terms.
// Throughput: one item at a time; the next transfer is taken the cycle after the
// result is loaded.
// Reset clears the history count, score and last stored time and sets the interval to 1000.
module fire_risk_score_fusion_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] timestamp_ms,
	input  logic signed [11:0] temperature,
	input  logic [15:0] air_ppm,
	input  logic [15:0] light_lux,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] fire_score,
	output logic        fire_detected,
	output logic        sample_taken
);
	import fsf_pkg::*;

	fsf_state_t state_q, state_d;

	logic [15:0]      interval_q;
	logic [31:0]      last_q;
	logic [CNT_W-1:0] cnt_q;
	logic [13:0]      score_q;
	logic             taken_q;
	logic [KW-1:0]    k_q;
	sample_t          prev_q;
	logic signed [TS_W-1:0] tsum_q;
	logic [LS_W-1:0]  lsum_q;
	logic [11:0]      rise_q;
	logic [15:0]      drop_q;
	logic signed [TN_W-1:0] tnum_q;
	logic [TD_W-1:0]  tden_q;
	logic [11:0]      tpart_q;
	logic [9:0]       lpart_q;
	logic             out_valid_q;
	logic [13:0]      out_score_q;
	logic             out_fire_q;
	logic             out_taken_q;

	sample_t          cell_q [RING_DEPTH];
	sample_t          cell_d [RING_DEPTH];
	sample_t          new_s;
	sample_t          tap;
	logic             shift_en;
	logic             in_acc;
	logic             gate;
	logic [31:0]      elapsed;
	logic [CNT_W-1:0] cnt_n;
	logic [CNT_W-1:0] skip;
	logic             el_valid;
	logic             el_first;
	logic             k_last;
	logic signed [12:0] dtemp;
	logic [31:0]      dt;
	logic             rise_go;
	logic [11:0]      rval;
	logic [13:0]      apart;
	logic [13:0]      nw;
	logic [13:0]      decay;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign new_s    = '{ts: timestamp_ms, temp: temperature, air: air_ppm, lux: light_lux};
	assign tap      = cell_q[RING_DEPTH-1];
	assign elapsed  = timestamp_ms - last_q;
	assign gate     = elapsed >= {16'b0, interval_q};
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign cnt_n    = (cnt_q == CNT_W'(RING_DEPTH)) ? cnt_q : cnt_q + 1'b1;
	assign shift_en = (in_acc && gate) || (state_q == ST_WALK);

	assign skip     = CNT_W'(RING_DEPTH) - cnt_q;
	assign el_valid = CNT_W'(k_q) >= skip;
	assign el_first = CNT_W'(k_q) == skip;
	assign k_last   = k_q == KW'(RING_DEPTH - 1);
	assign dtemp    = {tap.temp[11], tap.temp} - {prev_q.temp[11], prev_q.temp};
	assign dt       = tap.ts - prev_q.ts;
	assign rise_go  = el_valid && !el_first && !dtemp[12] && (dtemp != '0) && (dt != '0);

	assign rval  = (div_rsp.q[Q_W-1] || (div_rsp.q[Q_W-2:0] > 12'(RISE_MAX))) ?
	               12'(RISE_MAX) : div_rsp.q[11:0];
	assign apart = (drop_q >= 16'(AIR_SAT)) ? 14'(AIR_MAX) : {drop_q[11:0], 2'b00};
	assign nw    = 14'(tpart_q) + 14'(rise_q) + apart + 14'(lpart_q);
	assign decay = score_q - ((score_q - nw) >> 1);

	always_comb begin
		cell_d[0] = (state_q == ST_IDLE) ? new_s : tap;
		for (int i = 1; i < RING_DEPTH; i++) begin
			cell_d[i] = cell_q[i-1];
		end
	end

	for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
		fsf_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (cell_d[g]),
			.q        (cell_q[g])
		);
	end

	fsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.num   = NUM_W'(RISE_K * dtemp[11:0]);
		div_req.den   = dt;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (gate && cnt_n >= CNT_W'(MIN_SAMPLES)) begin
						state_d = ST_WALK;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_WALK: begin
				if (rise_go) begin
					div_req.start = 1'b1;
					state_d       = ST_RWAIT;
				end else if (k_last) begin
					state_d = ST_TPRE;
				end
			end
			ST_RWAIT: begin
				if (div_rsp.done) begin
					state_d = (k_q == '0) ? ST_TPRE : ST_WALK;
				end
			end
			ST_TPRE: state_d = ST_TCHK;
			ST_TCHK: begin
				div_req.num = NUM_W'(TEMP_MAX * tnum_q);
				div_req.den = DEN_W'(tden_q);
				if (tnum_q <= 0 || tnum_q >= $signed(TN_W'(tden_q))) begin
					state_d = ST_LCHK;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_TWAIT;
				end
			end
			ST_TWAIT: begin
				if (div_rsp.done) begin
					state_d = ST_LCHK;
				end
			end
			ST_LCHK: begin
				div_req.num = NUM_W'(lsum_q);
				div_req.den = DEN_W'(cnt_q);
				if (lsum_q >= LS_W'(LUX_DARK * cnt_q)) begin
					state_d = ST_UPD;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_LWAIT;
				end
			end
			ST_LWAIT: begin
				if (div_rsp.done) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: state_d = ST_FIN;
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			interval_q  <= 16'(INTERVAL_RST);
			last_q      <= '0;
			cnt_q       <= '0;
			score_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				interval_q <= cfg_wdata;
			end
			if (in_acc && gate) begin
				last_q <= timestamp_ms;
				cnt_q  <= cnt_n;
				if (cnt_n < CNT_W'(MIN_SAMPLES)) begin
					score_q <= '0;
				end
			end
			if (state_q == ST_UPD) begin
				if (nw < score_q) begin
					if (nw < 14'(DECAY_NEW_TH) && decay > 14'(DECAY_S_TH)) begin
						score_q <= decay - 14'(DECAY_STEP);
					end else begin
						score_q <= decay;
					end
				end else begin
					score_q <= (nw > 14'(SCORE_MAX)) ? 14'(SCORE_MAX) : nw;
				end
			end
			if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			taken_q <= gate;
			k_q     <= '0;
			tsum_q  <= '0;
			lsum_q  <= '0;
			rise_q  <= '0;
			drop_q  <= '0;
			tpart_q <= '0;
			lpart_q <= '0;
		end
		if (state_q == ST_WALK) begin
			prev_q <= tap;
			k_q    <= k_last ? '0 : k_q + 1'b1;
			if (el_valid) begin
				tsum_q <= tsum_q + TS_W'($signed(tap.temp));
				lsum_q <= lsum_q + LS_W'(tap.lux);
				if (!el_first && prev_q.air > tap.air && (prev_q.air - tap.air) > drop_q) begin
					drop_q <= prev_q.air - tap.air;
				end
			end
		end
		if (state_q == ST_RWAIT && div_rsp.done && rval > rise_q) begin
			rise_q <= rval;
		end
		if (state_q == ST_TPRE) begin
			tnum_q <= TN_W'(tsum_q) - TN_W'(TEMP_OFS * cnt_q);
			tden_q <= TD_W'(TEMP_SPAN * cnt_q);
		end
		if (state_q == ST_TCHK && tnum_q > 0 && tnum_q >= $signed(TN_W'(tden_q))) begin
			tpart_q <= 12'(TEMP_MAX);
		end
		if (state_q == ST_TWAIT && div_rsp.done) begin
			tpart_q <= div_rsp.q[11:0];
		end
		if (state_q == ST_LWAIT && div_rsp.done) begin
			lpart_q <= 10'(LUX_K * (LUX_DARK - int'(div_rsp.q[4:0])));
		end
		if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
			out_score_q <= score_q;
			out_fire_q  <= score_q >= 14'(FIRE_TH);
			out_taken_q <= taken_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign fire_score    = out_score_q;
	assign fire_detected = out_fire_q;
	assign sample_taken  = out_taken_q;

	assert property (@(posedge clk) disable iff (!arst_n) div_req.start |-> !div_rsp.busy)
		else $error("Divider started while a division is still running.");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(RING_DEPTH))
		else $error("History count exceeds the chain depth.");
	assert property (@(posedge clk) disable iff (!arst_n) score_q <= 14'(SCORE_MAX))
		else $error("Score register above its full-scale value.");
	assert property (@(posedge clk) disable iff (!arst_n) in_acc |=> (state_q != ST_IDLE))
		else $error("Sequencer stayed idle after an input transfer.");

endmodule
